/* hw/rtl/toq_pkg.sv */
// ----------------------------------------------------------------------------
// Time-ordered event queue package
// Shared constants, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package toq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int BURST         = 16;
   localparam int BURST_W       = $clog2(BURST + 1);

   localparam int OPCODE_W = 2;
   localparam int DEVICE_W = 8;
   localparam int VALUE_W  = 32;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OPCODE_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_PROCESS = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PEEK    = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_IGNORE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMITTED  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE_DUE = 2'd3;

   typedef struct packed {
      logic                load;
      logic                insert;
      logic                pop;
      logic                emit;
      logic [STATUS_W-1:0] emit_status;
      logic                emit_head;
      logic                emit_last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic head_due;
      logic next_due;
   } stat_type;

endpackage

/* hw/rtl/toq_ctrl.sv */
// ----------------------------------------------------------------------------
// Time-ordered event queue controller
// Sequences insert, process and peek items and counts the events emitted
// by one process item.
// ----------------------------------------------------------------------------
module toq_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [toq_pkg::OPCODE_W-1:0]   req_opcode,
   input  toq_pkg::stat_type              stat,
   output toq_pkg::cmd_type               cmd,
   output logic                           busy
);
   import toq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_INS  = 2'd1;
   localparam logic [1:0] S_PROC = 2'd2;
   localparam logic [1:0] S_PEEK = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [BURST_W-1:0] burst_ff, burst_in;
   logic               more;

   assign busy = (state_ff != S_IDLE);
   assign more = stat.next_due && ((burst_ff + BURST_W'(1)) < BURST_W'(BURST));

   always_comb begin
      state_in = state_ff;
      burst_in = '0;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_opcode)
                  OP_INSERT:  state_in = S_INS;
                  OP_PROCESS: state_in = S_PROC;
                  OP_PEEK:    state_in = S_PEEK;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_INS: begin
            cmd.insert      = !stat.full;
            cmd.emit        = 1'b1;
            cmd.emit_status = stat.full ? ST_DROPPED : ST_INSERTED;
            cmd.emit_last   = 1'b1;
            state_in        = S_IDLE;
         end
         S_PEEK: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = stat.empty ? ST_NONE_DUE : ST_EMITTED;
            cmd.emit_head   = !stat.empty;
            cmd.emit_last   = 1'b1;
            state_in        = S_IDLE;
         end
         S_PROC: begin
            cmd.emit = 1'b1;
            if (stat.head_due && (burst_ff < BURST_W'(BURST))) begin
               cmd.pop         = 1'b1;
               cmd.emit_status = ST_EMITTED;
               cmd.emit_head   = 1'b1;
               cmd.emit_last   = !more;
               burst_in        = burst_ff + BURST_W'(1);
               state_in        = more ? S_PROC : S_IDLE;
            end else begin
               cmd.emit_status = ST_NONE_DUE;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         burst_ff <= '0;
      end else begin
         state_ff <= state_in;
         burst_ff <= burst_in;
      end
   end

endmodule

/* hw/rtl/toq_dpath.sv */
// ----------------------------------------------------------------------------
// Time-ordered event queue datapath
// A row of sorted event cells with shift-insert and pop-from-head, the
// captured request fields and the registered result.
// ----------------------------------------------------------------------------
module toq_dpath #(
   parameter int DEPTH = toq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  toq_pkg::cmd_type                    cmd,
   output toq_pkg::stat_type                   stat,
   input  logic        [toq_pkg::DEVICE_W-1:0] req_device_id,
   input  logic signed [toq_pkg::VALUE_W-1:0]  req_event_value,
   input  logic        [toq_pkg::TIME_W-1:0]   req_event_time,
   input  logic        [toq_pkg::TIME_W-1:0]   req_now_time,
   output logic                                rsp_strobe,
   output logic        [toq_pkg::STATUS_W-1:0] rsp_status,
   output logic        [toq_pkg::DEVICE_W-1:0] rsp_out_device,
   output logic signed [toq_pkg::VALUE_W-1:0]  rsp_out_value,
   output logic        [toq_pkg::TIME_W-1:0]   rsp_out_time,
   output logic                                rsp_last_of_run,
   output logic        [toq_pkg::COUNT_W-1:0]  rsp_queue_count
);
   import toq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic        [TIME_W-1:0]   time_ff [DEPTH];
   logic        [TIME_W-1:0]   time_in [DEPTH];
   logic        [DEVICE_W-1:0] dev_ff  [DEPTH];
   logic        [DEVICE_W-1:0] dev_in  [DEPTH];
   logic signed [VALUE_W-1:0]  val_ff  [DEPTH];
   logic signed [VALUE_W-1:0]  val_in  [DEPTH];
   logic        [DEPTH-1:0]    ge;

   logic        [CW-1:0]       count_ff, count_in;
   logic        [DEVICE_W-1:0] new_dev_ff;
   logic signed [VALUE_W-1:0]  new_val_ff;
   logic        [TIME_W-1:0]   new_time_ff;
   logic        [TIME_W-1:0]   now_ff;

   logic                       rsp_strobe_ff;
   logic        [STATUS_W-1:0] rsp_status_ff;
   logic        [DEVICE_W-1:0] rsp_device_ff;
   logic signed [VALUE_W-1:0]  rsp_value_ff;
   logic        [TIME_W-1:0]   rsp_time_ff;
   logic                       rsp_last_ff;
   logic        [COUNT_W-1:0]  rsp_count_ff;

   assign stat.full     = (count_ff == CW'(DEPTH));
   assign stat.empty    = (count_ff == '0);
   assign stat.head_due = !stat.empty && (time_ff[0] <= now_ff);
   assign stat.next_due = (count_ff > CW'(1)) && (time_ff[1] <= now_ff);

   genvar g;
   for (g = 0; g < DEPTH; g++) begin : g_cell
      logic take_new, take_prev;

      assign ge[g] = (CW'(g) < count_ff) && (time_ff[g] <= new_time_ff);

      if (g == 0) begin : g_head
         assign take_new  = !ge[0];
         assign take_prev = 1'b0;
      end else begin : g_body
         assign take_new  = !ge[g] && ge[g-1];
         assign take_prev = !ge[g-1];
      end

      always_comb begin
         time_in[g] = time_ff[g];
         dev_in[g]  = dev_ff[g];
         val_in[g]  = val_ff[g];
         if (cmd.insert) begin
            if (take_new) begin
               time_in[g] = new_time_ff;
               dev_in[g]  = new_dev_ff;
               val_in[g]  = new_val_ff;
            end else if (take_prev) begin
               time_in[g] = time_ff[(g == 0) ? 0 : g - 1];
               dev_in[g]  = dev_ff[(g == 0) ? 0 : g - 1];
               val_in[g]  = val_ff[(g == 0) ? 0 : g - 1];
            end
         end else if (cmd.pop && (g < DEPTH - 1)) begin
            time_in[g] = time_ff[(g < DEPTH - 1) ? g + 1 : g];
            dev_in[g]  = dev_ff[(g < DEPTH - 1) ? g + 1 : g];
            val_in[g]  = val_ff[(g < DEPTH - 1) ? g + 1 : g];
         end
      end

      always_ff @(posedge clock) begin
         time_ff[g] <= time_in[g];
         dev_ff[g]  <= dev_in[g];
         val_ff[g]  <= val_in[g];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         new_dev_ff  <= req_device_id;
         new_val_ff  <= req_event_value;
         new_time_ff <= req_event_time;
         now_ff      <= req_now_time;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_device_ff <= cmd.emit_head ? dev_ff[0]  : '0;
         rsp_value_ff  <= cmd.emit_head ? val_ff[0]  : '0;
         rsp_time_ff   <= cmd.emit_head ? time_ff[0] : '0;
         rsp_last_ff   <= cmd.emit_last;
         rsp_count_ff  <= COUNT_W'(count_in);
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_device  = rsp_device_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_out_time    = rsp_time_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_queue_count = rsp_count_ff;

endmodule

/* hw/rtl/time_ordered_event_queue_top.sv */
// ----------------------------------------------------------------------------
// Time-ordered event queue
// Holds up to DEPTH events sorted by due time, first come first served on
// equal times; inserts, emits due events from the head and peeks the head.
//
//   Channel   Ports                        Handshake
//   request   req_*                        start high while busy low
//   result    rsp_*                        rsp_strobe, high with each result
//
// An insert or peek first captures the request; then an insert updates
// the cell row, and either item registers its result.
// A process item first captures the request, then emits due events back to
// back (at most BURST), each popping one cell from the head of the row.
// Each result is registered in the cycle after the controller issues it.
// Reset empties the queue at once; there is no clearing pass.
// The receiver cannot stall; busy alone holds off new items.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_top #(
   parameter int DEPTH = toq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic        [toq_pkg::OPCODE_W-1:0] req_opcode,
   input  logic        [toq_pkg::DEVICE_W-1:0] req_device_id,
   input  logic signed [toq_pkg::VALUE_W-1:0]  req_event_value,
   input  logic        [toq_pkg::TIME_W-1:0]   req_event_time,
   input  logic        [toq_pkg::TIME_W-1:0]   req_now_time,
   output logic                                rsp_strobe,
   output logic        [toq_pkg::STATUS_W-1:0] rsp_status,
   output logic        [toq_pkg::DEVICE_W-1:0] rsp_out_device,
   output logic signed [toq_pkg::VALUE_W-1:0]  rsp_out_value,
   output logic        [toq_pkg::TIME_W-1:0]   rsp_out_time,
   output logic                                rsp_last_of_run,
   output logic        [toq_pkg::COUNT_W-1:0]  rsp_queue_count
);
   import toq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   toq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   toq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_device_id   (req_device_id),
      .req_event_value (req_event_value),
      .req_event_time  (req_event_time),
      .req_now_time    (req_now_time),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_out_device  (rsp_out_device),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_time    (rsp_out_time),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_queue_count (rsp_queue_count)
   );

endmodule

/* hw/rtl/toq_checker.sv */
// ----------------------------------------------------------------------------
// Time-ordered event queue checker
// Watches the top-level ports and checks result sequencing over time.
// ----------------------------------------------------------------------------
module toq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic        [toq_pkg::OPCODE_W-1:0] req_opcode,
   input logic                                rsp_strobe,
   input logic        [toq_pkg::STATUS_W-1:0] rsp_status,
   input logic        [toq_pkg::DEVICE_W-1:0] rsp_out_device,
   input logic signed [toq_pkg::VALUE_W-1:0]  rsp_out_value,
   input logic        [toq_pkg::TIME_W-1:0]   rsp_out_time,
   input logic                                rsp_last_of_run,
   input logic        [toq_pkg::COUNT_W-1:0]  rsp_queue_count
);
   import toq_pkg::*;

   a_insert_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == OP_INSERT) |=> busy)
      else $error("insert item not followed by busy");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && ((rsp_status == ST_INSERTED) || (rsp_status == ST_DROPPED)
                     || (rsp_status == ST_NONE_DUE)) |-> rsp_last_of_run)
      else $error("single-result item not marked last");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_NONE_DUE) |->
         (rsp_out_device == '0) && (rsp_out_value == '0) && (rsp_out_time == '0))
      else $error("none-due result carries a payload");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_run |=> rsp_strobe && (rsp_status == ST_EMITTED))
      else $error("emission run broken before its last item");

   a_run_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_run |=>
         ((rsp_queue_count + COUNT_W'(1)) == $past(rsp_queue_count)))
      else $error("queue count not decremented during emission run");

endmodule

bind time_ordered_event_queue_top toq_checker u_toq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_opcode      (req_opcode),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_out_device  (rsp_out_device),
   .rsp_out_value   (rsp_out_value),
   .rsp_out_time    (rsp_out_time),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_queue_count (rsp_queue_count)
);
